// ===== rtl/motor_command_to_pwm_compare_defines.svh =====
// Assertion macros for the motor command to PWM compare block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef MOTOR_COMMAND_TO_PWM_COMPARE_DEFINES_SVH
`define MOTOR_COMMAND_TO_PWM_COMPARE_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define MCTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define MCTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mctp_pkg.sv =====
// Shared types, constants and helpers for the motor command to PWM compare block.
// No dependencies; every other RTL module imports this package.
`default_nettype none

package mctp_pkg;

    localparam int COMPARE_WIDTH = 16;
    localparam int ADDR_W        = 5;
    localparam int DIV_STEPS     = 14;
    localparam int DUTY_W        = 14;
    localparam int RECIP_SHIFT   = 45;
    localparam int QUOT_W        = 63 - RECIP_SHIFT;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;
    localparam logic [12:0]       DUTY_HALF = 13'd5000;
    // ceil(2^45 / 10000): exact floor division for dividends below 2^31
    localparam logic [31:0]       RECIP_10K = 32'd3518437209;
    localparam logic [32:0]       PULSE_CAP = (33'd1 << COMPARE_WIDTH) - 33'd1;

    typedef enum logic [2:0] {
        REG_VOLT_MIN     = 3'd0,
        REG_VOLT_MAX     = 3'd1,
        REG_VOLT_NEUTRAL = 3'd2,
        REG_VOLT_REF     = 3'd3,
        REG_DUTY_FLOOR   = 3'd4,
        REG_DUTY_CEILING = 3'd5,
        REG_PWM_PERIOD   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] command;
        logic signed [15:0] voltage_in_mv;
    } item_t;

    typedef struct packed {
        logic [COMPARE_WIDTH-1:0] compare_value;
        logic signed [15:0]       voltage_out_mv;
        logic [DUTY_W-1:0]        duty_out;
    } result_t;

    typedef struct packed {
        logic signed [15:0] volt_min_mv;
        logic signed [15:0] volt_max_mv;
        logic signed [15:0] volt_neutral_mv;
        logic [15:0]        volt_reference_mv;
        logic [DUTY_W-1:0]  duty_floor;
        logic [DUTY_W-1:0]  duty_ceiling;
        logic [16:0]        pwm_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        volt_min_mv:       16'sd0,
        volt_max_mv:       16'sd3300,
        volt_neutral_mv:   16'sd1650,
        volt_reference_mv: 16'd3300,
        duty_floor:        14'd0,
        duty_ceiling:      14'd10000,
        pwm_period:        17'd65536
    };

    // Clamped voltage handed from the mapping stages to the duty stages
    typedef struct packed {
        logic               valid;
        logic signed [15:0] volt;
    } vstage_t;

    // Voltage and clamped duty handed to the pulse stages
    typedef struct packed {
        logic               valid;
        logic signed [15:0] volt;
        logic [DUTY_W-1:0]  duty;
    } dstage_t;

    // Low bound tested first, then the high bound
    function automatic logic signed [17:0] clamp_volt(
        input logic signed [17:0] x,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [17:0] lo_x;
        logic signed [17:0] hi_x;
        logic signed [17:0] res;
        lo_x = 18'(lo);
        hi_x = 18'(hi);
        if (x < lo_x)
        begin
            res = lo_x;
        end
        else if (x > hi_x)
        begin
            res = hi_x;
        end
        else
        begin
            res = x;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mctp_regs.sv =====
// APB configuration register file for the motor command to PWM compare block.
// Depends on mctp_pkg for the register layout and reset values.
`default_nettype none

module mctp_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mctp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output mctp_pkg::cfg_t                  cfg
);
    import mctp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_VOLT_MIN:     cfg_next.volt_min_mv       = pwdata[15:0];
                REG_VOLT_MAX:     cfg_next.volt_max_mv       = pwdata[15:0];
                REG_VOLT_NEUTRAL: cfg_next.volt_neutral_mv   = pwdata[15:0];
                REG_VOLT_REF:     cfg_next.volt_reference_mv = pwdata[15:0];
                REG_DUTY_FLOOR:   cfg_next.duty_floor        = pwdata[DUTY_W-1:0];
                REG_DUTY_CEILING: cfg_next.duty_ceiling      = pwdata[DUTY_W-1:0];
                REG_PWM_PERIOD:   cfg_next.pwm_period        = pwdata[16:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_VOLT_MIN:     prdata = {16'b0, cfg_reg.volt_min_mv};
            REG_VOLT_MAX:     prdata = {16'b0, cfg_reg.volt_max_mv};
            REG_VOLT_NEUTRAL: prdata = {16'b0, cfg_reg.volt_neutral_mv};
            REG_VOLT_REF:     prdata = {16'b0, cfg_reg.volt_reference_mv};
            REG_DUTY_FLOOR:   prdata = {18'b0, cfg_reg.duty_floor};
            REG_DUTY_CEILING: prdata = {18'b0, cfg_reg.duty_ceiling};
            REG_PWM_PERIOD:   prdata = {15'b0, cfg_reg.pwm_period};
            default:          prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mctp_vmap.sv =====
// Command mapping and voltage clamp stages: three register stages.
// Depends on mctp_pkg for the item, config and stage types.
`default_nettype none

module mctp_vmap (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire mctp_pkg::item_t item,
    input  wire mctp_pkg::cfg_t  cfg,
    output mctp_pkg::vstage_t    vout
);
    import mctp_pkg::*;

    // stage 1: command times span
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic signed [32:0] s1_prod_reg;
    logic signed [15:0] s1_vin_reg;
    logic signed [16:0] span;
    logic signed [32:0] s1_prod_next;

    // stage 2: rounded offset around neutral
    logic               s2_valid_reg;
    logic               s2_twice_reg;
    logic signed [17:0] s2_volt_reg;
    logic [32:0]        mag;
    logic [32:0]        rnd;
    logic signed [17:0] off;
    logic signed [17:0] s2_volt_next;

    // stage 3: limit clamp
    logic               s3_valid_reg;
    logic signed [15:0] s3_volt_reg;
    logic signed [17:0] clamp_once;
    logic signed [17:0] s3_volt_next;

    always_comb
    begin
        if (item.command >= 16'sd0)
        begin
            span = 17'(cfg.volt_max_mv) - 17'(cfg.volt_neutral_mv);
        end
        else
        begin
            span = 17'(cfg.volt_neutral_mv) - 17'(cfg.volt_min_mv);
        end
        s1_prod_next = 33'(item.command) * 33'(span);
    end

    always_comb
    begin
        mag = s1_prod_reg[32] ? (~s1_prod_reg + 33'd1) : s1_prod_reg;
        rnd = mag + 33'd16384;
        off = $signed({1'b0, rnd[31:15]});
        if (s1_prod_reg[32])
        begin
            off = -off;
        end
        if (s1_op_reg)
        begin
            s2_volt_next = 18'(s1_vin_reg);
        end
        else
        begin
            s2_volt_next = 18'(cfg.volt_neutral_mv) + off;
        end
    end

    // mapped commands see the clamp twice; with inverted limits the second pass matters
    always_comb
    begin
        clamp_once = clamp_volt(s2_volt_reg, cfg.volt_min_mv, cfg.volt_max_mv);
        if (s2_twice_reg)
        begin
            s3_volt_next = clamp_volt(clamp_once, cfg.volt_min_mv, cfg.volt_max_mv);
        end
        else
        begin
            s3_volt_next = clamp_once;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= item.opcode;
        s1_prod_reg  <= s1_prod_next;
        s1_vin_reg   <= item.voltage_in_mv;
        s2_twice_reg <= ~s1_op_reg;
        s2_volt_reg  <= s2_volt_next;
        s3_volt_reg  <= s3_volt_next[15:0];
    end

    assign vout.valid = s3_valid_reg;
    assign vout.volt  = s3_volt_reg;

endmodule

`default_nettype wire

// ===== rtl/mctp_duty.sv =====
// Voltage to duty conversion: pipelined restoring divider, one quotient bit per stage,
// followed by the duty clamp. Depends on mctp_pkg.
`default_nettype none

module mctp_duty (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mctp_pkg::vstage_t vin,
    input  wire mctp_pkg::cfg_t    cfg,
    output mctp_pkg::dstage_t      dout
);
    import mctp_pkg::*;

    typedef struct packed {
        logic               neg;
        logic               over;
        logic signed [15:0] volt;
        logic [29:0]        rem;
        logic [DIV_STEPS-1:0] quo;
    } div_slot_t;

    logic [15:0]        vref;
    logic [16:0]        den;

    // stage A: numerator 2*|v|*10000 + vref
    logic               a_valid_reg;
    logic               a_neg_reg;
    logic signed [15:0] a_volt_reg;
    logic [29:0]        a_num_reg;
    logic [16:0]        vabs;
    logic [28:0]        scaled;
    logic [29:0]        a_num_next;

    logic [DIV_STEPS:0] dv_reg;
    div_slot_t          slot_reg  [0:DIV_STEPS];
    div_slot_t          slot_next [0:DIV_STEPS];

    // clamp stage
    logic               c_valid_reg;
    logic signed [15:0] c_volt_reg;
    logic [DUTY_W-1:0]  c_duty_reg;
    logic [DUTY_W-1:0]  c_duty_next;
    div_slot_t          last;

    assign vref = (cfg.volt_reference_mv == 16'd0) ? 16'd1 : cfg.volt_reference_mv;
    assign den  = {vref, 1'b0};

    always_comb
    begin
        vabs       = vin.volt[15] ? (17'd0 - 17'(vin.volt)) : 17'(vin.volt);
        scaled     = 29'(vabs) * 29'(DUTY_FULL);
        a_num_next = {scaled, 1'b0} + 30'(vref);
    end

    always_comb
    begin
        slot_next[0].neg  = a_neg_reg;
        slot_next[0].volt = a_volt_reg;
        slot_next[0].rem  = a_num_reg;
        slot_next[0].quo  = '0;
        // quotient would not fit the duty range: saturate instead of dividing
        slot_next[0].over = 31'(a_num_reg) >= (31'(den) << DIV_STEPS);
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            slot_next[i+1] = slot_reg[i];
            if (slot_reg[i].rem >= (30'(den) << (DIV_STEPS - 1 - i)))
            begin
                slot_next[i+1].rem = slot_reg[i].rem - (30'(den) << (DIV_STEPS - 1 - i));
                slot_next[i+1].quo[DIV_STEPS - 1 - i] = 1'b1;
            end
        end
    end

    assign last = slot_reg[DIV_STEPS];

    always_comb
    begin
        if (last.neg && (last.over || (last.quo != '0)))
        begin
            c_duty_next = cfg.duty_floor;
        end
        else if (!last.over && (last.quo < cfg.duty_floor))
        begin
            c_duty_next = cfg.duty_floor;
        end
        else if (last.over || (last.quo > cfg.duty_ceiling))
        begin
            c_duty_next = cfg.duty_ceiling;
        end
        else
        begin
            c_duty_next = last.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            dv_reg      <= '0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= vin.valid;
            dv_reg      <= {dv_reg[DIV_STEPS-1:0], a_valid_reg};
            c_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        a_neg_reg  <= vin.volt[15];
        a_volt_reg <= vin.volt;
        a_num_reg  <= a_num_next;
        slot_reg   <= slot_next;
        c_volt_reg <= last.volt;
        c_duty_reg <= c_duty_next;
    end

    assign dout.valid = c_valid_reg;
    assign dout.volt  = c_volt_reg;
    assign dout.duty  = c_duty_reg;

endmodule

`default_nettype wire

// ===== rtl/mctp_pulse.sv =====
// Duty to compare count: multiply by period, divide by 10000 through a reciprocal,
// then limit to period minus one and the compare width. Depends on mctp_pkg.
`default_nettype none

module mctp_pulse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mctp_pkg::dstage_t din,
    input  wire mctp_pkg::cfg_t    cfg,
    output logic                   done,
    output mctp_pkg::result_t      result
);
    import mctp_pkg::*;

    logic [2:0]         pv_reg;

    logic signed [15:0] p1_volt_reg;
    logic [DUTY_W-1:0]  p1_duty_reg;
    logic [30:0]        p1_prod_reg;
    logic [30:0]        p1_prod_next;

    logic signed [15:0] p2_volt_reg;
    logic [DUTY_W-1:0]  p2_duty_reg;
    logic [62:0]        p2_prod_reg;
    logic [30:0]        biased;
    logic [62:0]        p2_prod_next;

    result_t            res_reg;
    logic [QUOT_W-1:0]  quot;
    logic [QUOT_W-1:0]  pulse_lim;
    logic [16:0]        top_count;
    logic [COMPARE_WIDTH-1:0] cmp_next;

    assign p1_prod_next = 31'(din.duty) * 31'(cfg.pwm_period);
    assign biased       = p1_prod_reg + 31'(DUTY_HALF);
    assign p2_prod_next = 63'(biased) * 63'(RECIP_10K);

    always_comb
    begin
        quot      = p2_prod_reg[62:RECIP_SHIFT];
        top_count = cfg.pwm_period - 17'd1;
        if (cfg.pwm_period == 17'd0)
        begin
            pulse_lim = '0;
        end
        else if (quot > QUOT_W'(top_count))
        begin
            pulse_lim = QUOT_W'(top_count);
        end
        else
        begin
            pulse_lim = quot;
        end
        if (33'(pulse_lim) > PULSE_CAP)
        begin
            cmp_next = COMPARE_WIDTH'(PULSE_CAP);
        end
        else
        begin
            cmp_next = COMPARE_WIDTH'(pulse_lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[1:0], din.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_volt_reg            <= din.volt;
        p1_duty_reg            <= din.duty;
        p1_prod_reg            <= p1_prod_next;
        p2_volt_reg            <= p1_volt_reg;
        p2_duty_reg            <= p1_duty_reg;
        p2_prod_reg            <= p2_prod_next;
        res_reg.compare_value  <= cmp_next;
        res_reg.voltage_out_mv <= p2_volt_reg;
        res_reg.duty_out       <= p2_duty_reg;
    end

    assign done   = pv_reg[2];
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/motor_command_to_pwm_compare.sv =====
// Top level of the motor command to PWM compare block.
// Instantiates mctp_regs, mctp_vmap, mctp_duty and mctp_pulse; uses mctp_pkg and the defines header.
//
// Usage:
//   Items enter on start/item and are taken at any edge where start is high and busy
//   is low. Opcode 0 maps a Q1.15 command around the neutral voltage; opcode 1 takes
//   voltage_in_mv directly. Each item gives one result on the result port, marked by
//   done for exactly one cycle; the receiver cannot stall, so results are never held.
//   From accept to done an item passes the command mapping and voltage clamp stages, the
//   duty divider (setup, saturation test, one quotient bit per stage over 14 stages, then
//   clamp) and the period scaling multipliers. Throughput is one item per cycle while
//   busy is low; every stage is a plain register with a valid bit. Configuration goes
//   through the APB port (register i at byte address 4*i, pready always high); the user
//   must write it only while no item is in flight, as the block does not enforce this.
//   Reset clears all valid bits and loads the register defaults; busy stays high until
//   the first edge after reset is released.
`default_nettype none

`include "motor_command_to_pwm_compare_defines.svh"

module motor_command_to_pwm_compare (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire mctp_pkg::item_t             item,
    output logic                             done,
    output mctp_pkg::result_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mctp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import mctp_pkg::*;

    cfg_t    cfg;
    vstage_t vst;
    dstage_t dst;
    logic    accept;
    logic    busy_reg;
    logic    busy_next;

    assign busy_next = 1'b0;
    assign busy      = busy_reg;
    assign accept    = start & ~busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    mctp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mctp_vmap u_vmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .vout   (vst)
    );

    mctp_duty u_duty (
        .clk   (clk),
        .rst_n (rst_n),
        .vin   (vst),
        .cfg   (cfg),
        .dout  (dst)
    );

    mctp_pulse u_pulse (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (dst),
        .cfg    (cfg),
        .done   (done),
        .result (result)
    );

    `MCTP_ASSERT_NOW(a_duty_in_limits, done && (cfg.duty_floor <= cfg.duty_ceiling), (result.duty_out >= cfg.duty_floor) && (result.duty_out <= cfg.duty_ceiling), "duty outside floor/ceiling")
    `MCTP_ASSERT_NOW(a_volt_in_limits, done && (cfg.volt_min_mv <= cfg.volt_max_mv), (result.voltage_out_mv >= cfg.volt_min_mv) && (result.voltage_out_mv <= cfg.volt_max_mv), "voltage outside limits")
    `MCTP_ASSERT_NOW(a_compare_below_period, done && (cfg.pwm_period != 17'd0), 33'(result.compare_value) < 33'(cfg.pwm_period), "compare value not below period")
    `MCTP_ASSERT_NOW(a_zero_period, done && (cfg.pwm_period == 17'd0), result.compare_value == '0, "compare value nonzero with zero period")
    `MCTP_ASSERT_NEXT(a_ready_after_reset, 1'b1, !busy, "busy held after reset")

endmodule

`default_nettype wire
